// File: hdl/wua_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package wua_pkg;

    localparam int unsigned DATA_W  = 256;
    localparam int unsigned WORD_W  = 64;
    localparam int unsigned SHIFT_W = 6;
    localparam int unsigned CNT_W   = 9;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_MOD = 3'd4;
    localparam logic [2:0] OP_SHL = 3'd5;
    localparam logic [2:0] OP_SHR = 3'd6;
    localparam logic [2:0] OP_CMP = 3'd7;

    // Per-bit control shared by the serial datapath and the sequencer.
    typedef struct packed {
        logic       start;
        logic       step;
        logic [2:0] op;
    } wua_ctrl_t;

endpackage
`default_nettype wire

// File: hdl/wide_unsigned_integer_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel | Ports                                  | Direction
// s_      | op, a_word0..3, b_word0..3, shift_bytes | word in
// m_      | r_word0..3, a_less, a_equal, divide_by_zero | word out
//
// Every word is loaded and then runs 256 serial steps in the bit-serial loop,
// which handles one operand bit per cycle.
// Shifts move their bits only while the step count is below eight times the
// byte count, but still run the full 256-step sweep, since the compare flags need it.
// Reset is synchronous and active low; it clears only the sequencer.
// A finished word waits in the output register; a new word is accepted
// once the output register is free.
module wide_unsigned_integer_alu
    import wua_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [2:0]         s_op,
    input  wire logic [WORD_W-1:0]  s_a_word0,
    input  wire logic [WORD_W-1:0]  s_a_word1,
    input  wire logic [WORD_W-1:0]  s_a_word2,
    input  wire logic [WORD_W-1:0]  s_a_word3,
    input  wire logic [WORD_W-1:0]  s_b_word0,
    input  wire logic [WORD_W-1:0]  s_b_word1,
    input  wire logic [WORD_W-1:0]  s_b_word2,
    input  wire logic [WORD_W-1:0]  s_b_word3,
    input  wire logic [SHIFT_W-1:0] s_shift_bytes,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [WORD_W-1:0]       m_r_word0,
    output logic [WORD_W-1:0]       m_r_word1,
    output logic [WORD_W-1:0]       m_r_word2,
    output logic [WORD_W-1:0]       m_r_word3,
    output logic                    m_a_less,
    output logic                    m_a_equal,
    output logic                    m_divide_by_zero
);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  len_reg;
    logic [2:0]        op_reg;
    logic              dz_reg;
    logic              zero_reg;
    logic              accept;
    logic              bzero;
    wua_ctrl_t         ctrl;
    logic [DATA_W-1:0] a_cat, b_cat, core_r;
    logic              cmp_lt, cmp_eq;
    logic [DATA_W-1:0] res;
    logic [DATA_W-1:0] sh_reg;

    assign a_cat  = {s_a_word3, s_a_word2, s_a_word1, s_a_word0};
    assign b_cat  = {s_b_word3, s_b_word2, s_b_word1, s_b_word0};
    assign bzero  = (b_cat == '0);
    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;

    // Fields in order: start, step, op.
    assign ctrl = {accept, (state_reg == S_RUN), (accept ? s_op : op_reg)};

    wua_serial_core u_core (
        .aclk    (aclk),
        .ctrl    (ctrl),
        .a_in    (a_cat),
        .b_in    (b_cat),
        .r_out   (core_r)
    );

    wua_compare u_cmp (
        .aclk    (aclk),
        .ctrl    (ctrl),
        .a_in    (a_cat),
        .b_in    (b_cat),
        .a_less  (cmp_lt),
        .a_equal (cmp_eq)
    );

    // The compare sweep always runs the full width, so the loop length is the
    // full width for all ops; shifts stop moving their bits after the count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        op_reg    <= s_op;
                        dz_reg    <= (s_op == OP_DIV || s_op == OP_MOD) && bzero;
                        zero_reg  <= ((s_op == OP_DIV || s_op == OP_MOD) && bzero)
                                  || s_op == OP_CMP
                                  || ((s_op == OP_SHL || s_op == OP_SHR)
                                      && s_shift_bytes >= SHIFT_W'(32));
                        len_reg   <= {1'b0, s_shift_bytes[4:0], 3'b000};
                        cnt_reg   <= '0;
                        state_reg <= S_RUN;
                    end
                end
                S_RUN: begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(DATA_W - 1)) begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (m_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Shifts: a held copy of A moves one bit per cycle only while the count
    // is below the length, so it ends up moved by exactly eight bits a byte.
    always_ff @(posedge aclk) begin
        if (accept) begin
            sh_reg <= a_cat;
        end else if (state_reg == S_RUN && cnt_reg < len_reg) begin
            sh_reg <= (op_reg == OP_SHL) ? (sh_reg << 1) : (sh_reg >> 1);
        end
    end

    always_comb begin
        if (zero_reg) begin
            res = '0;
        end else if (op_reg == OP_SHL || op_reg == OP_SHR) begin
            res = sh_reg;
        end else begin
            res = core_r;
        end
    end

    assign m_valid          = (state_reg == S_DONE);
    assign m_r_word0        = res[WORD_W-1:0];
    assign m_r_word1        = res[2*WORD_W-1:WORD_W];
    assign m_r_word2        = res[3*WORD_W-1:2*WORD_W];
    assign m_r_word3        = res[4*WORD_W-1:3*WORD_W];
    assign m_a_less         = cmp_lt;
    assign m_a_equal        = cmp_eq;
    assign m_divide_by_zero = dz_reg;

endmodule
`default_nettype wire

// File: hdl/wua_serial_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Bit-serial datapath. Every step handles one bit: add and subtract ripple
// one carry bit LSB first, multiply is shift-and-add with B consumed LSB first,
// and divide is restoring long division with A consumed MSB first.
module wua_serial_core
    import wua_pkg::*;
(
    input  wire logic              aclk,
    input  wire wua_ctrl_t         ctrl,
    input  wire logic [DATA_W-1:0] a_in,
    input  wire logic [DATA_W-1:0] b_in,
    output logic [DATA_W-1:0]      r_out
);

    logic [DATA_W-1:0] a_reg, a_next;
    logic [DATA_W-1:0] b_reg, b_next;
    logic [DATA_W-1:0] d_reg, d_next;   // divisor or multiplicand
    logic [DATA_W-1:0] r_reg, r_next;   // result, remainder or sum
    logic [DATA_W-1:0] q_reg, q_next;
    logic              c_reg, c_next;

    logic [DATA_W-1:0] rem_sh;
    logic              rem_top;
    logic [DATA_W:0]   rem_diff;
    logic [1:0]        bsum;

    always_comb begin
        a_next  = a_reg;
        b_next  = b_reg;
        d_next  = d_reg;
        r_next  = r_reg;
        q_next  = q_reg;
        c_next  = c_reg;
        rem_top = r_reg[DATA_W-1];
        rem_sh  = {r_reg[DATA_W-2:0], a_reg[DATA_W-1]};
        rem_diff = {1'b0, rem_sh} - {1'b0, d_reg};
        bsum    = 2'b00;
        if (ctrl.start) begin
            a_next  = a_in;
            b_next  = b_in;
            d_next  = (ctrl.op == OP_MUL) ? a_in : b_in;
            r_next  = '0;
            q_next  = '0;
            c_next  = (ctrl.op == OP_SUB);
        end else if (ctrl.step) begin
            case (ctrl.op)
                OP_ADD, OP_SUB: begin
                    bsum   = {1'b0, a_reg[0]}
                           + {1'b0, (ctrl.op == OP_SUB) ? ~b_reg[0] : b_reg[0]}
                           + {1'b0, c_reg};
                    c_next = bsum[1];
                    r_next = {bsum[0], r_reg[DATA_W-1:1]};
                    a_next = a_reg >> 1;
                    b_next = b_reg >> 1;
                end
                OP_MUL: begin
                    if (b_reg[0]) begin
                        r_next = r_reg + d_reg;
                    end
                    d_next = d_reg << 1;
                    b_next = b_reg >> 1;
                end
                OP_DIV, OP_MOD: begin
                    if (rem_top || !rem_diff[DATA_W]) begin
                        r_next = rem_diff[DATA_W-1:0];
                        q_next = {q_reg[DATA_W-2:0], 1'b1};
                    end else begin
                        r_next = rem_sh;
                        q_next = {q_reg[DATA_W-2:0], 1'b0};
                    end
                    a_next = a_reg << 1;
                end
                default: begin
                    a_next = a_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        a_reg  <= a_next;
        b_reg  <= b_next;
        d_reg  <= d_next;
        r_reg  <= r_next;
        q_reg  <= q_next;
        c_reg  <= c_next;
    end

    assign r_out = (ctrl.op == OP_DIV) ? q_reg : r_reg;

endmodule
`default_nettype wire

// File: hdl/wua_compare.sv
`timescale 1ns / 1ps
`default_nettype none
// Serial magnitude compare: one bit per step, MSB first.
module wua_compare
    import wua_pkg::*;
(
    input  wire logic              aclk,
    input  wire wua_ctrl_t         ctrl,
    input  wire logic [DATA_W-1:0] a_in,
    input  wire logic [DATA_W-1:0] b_in,
    output logic                   a_less,
    output logic                   a_equal
);

    logic [DATA_W-1:0] x_reg, y_reg;
    logic              lt_reg, eq_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            x_reg  <= a_in;
            y_reg  <= b_in;
            lt_reg <= 1'b0;
            eq_reg <= 1'b1;
        end else if (ctrl.step) begin
            x_reg <= x_reg << 1;
            y_reg <= y_reg << 1;
            if (eq_reg && (x_reg[DATA_W-1] != y_reg[DATA_W-1])) begin
                eq_reg <= 1'b0;
                lt_reg <= y_reg[DATA_W-1];
            end
        end
    end

    assign a_less  = lt_reg;
    assign a_equal = eq_reg;

endmodule
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps

// Predicts results of the 256-bit ALU and checks returned words in order.
class alu_scoreboard;
    typedef struct {
        logic [255:0] r;
        logic         less;
        logic         equal;
        logic         dz;
    } alu_result_t;

    alu_result_t pending[$];
    int mismatches;

    function logic [255:0] long_divide(logic [255:0] a, logic [255:0] b, bit want_rem);
        logic [256:0] rem;
        logic [255:0] quo;
        quo = '0;
        rem = '0;
        for (int k = 255; k >= 0; k--) begin
            rem = {rem[255:0], a[k]};
            if (rem >= {1'b0, b}) begin
                rem = rem - {1'b0, b};
                quo[k] = 1'b1;
            end
        end
        return want_rem ? rem[255:0] : quo;
    endfunction

    function void note_operation(logic [2:0] op, logic [255:0] a, logic [255:0] b,
                                 logic [5:0] nbytes);
        alu_result_t e;
        logic [511:0] prod;
        e.r = '0;
        e.dz = 1'b0;
        e.less = a < b;
        e.equal = a == b;
        case (op)
            wua_pkg::OP_ADD: e.r = a + b;
            wua_pkg::OP_SUB: e.r = a - b;
            wua_pkg::OP_MUL: begin
                prod = a * b;
                e.r = prod[255:0];
            end
            wua_pkg::OP_DIV, wua_pkg::OP_MOD: begin
                if (b == '0) e.dz = 1'b1;
                else e.r = long_divide(a, b, op == wua_pkg::OP_MOD);
            end
            wua_pkg::OP_SHL: if (nbytes < 32) e.r = a << (8 * nbytes);
            wua_pkg::OP_SHR: if (nbytes < 32) e.r = a >> (8 * nbytes);
            default: ;
        endcase
        pending.insert(pending.size(), e);
    endfunction

    function void check_result(logic [255:0] r, logic less, logic equal, logic dz);
        alu_result_t e;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word r=%h", r);
            return;
        end
        e = pending.pop_front();
        if (r !== e.r || less !== e.less || equal !== e.equal || dz !== e.dz) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp r=%h l=%b e=%b dz=%b / got r=%h l=%b e=%b dz=%b",
                         e.r, e.less, e.equal, e.dz, r, less, equal, dz);
        end
    endfunction
endclass

module testbench;
    import wua_pkg::*;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic [2:0] s_op;
    logic [63:0] s_a_word0, s_a_word1, s_a_word2, s_a_word3;
    logic [63:0] s_b_word0, s_b_word1, s_b_word2, s_b_word3;
    logic [5:0] s_shift_bytes;
    logic m_valid;
    logic m_ready;
    logic [63:0] m_r_word0, m_r_word1, m_r_word2, m_r_word3;
    logic m_a_less, m_a_equal, m_divide_by_zero;

    alu_scoreboard board;
    // Set once the long receiver hold-off is due, so the block fills up.
    bit hold_off_now;
    bit stimulus_done;

    wide_unsigned_integer_alu uut (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Fixed wall on the run. The 520 words with receiver stalls stay far below
    // this bound.
    initial begin
        #2000000;
        $display("testbench: done, errors");
        $finish;
    end

    // Operands are drawn from a few shapes so that carries, borrows, small
    // divisors and equal operands all show up.
    function automatic logic [255:0] pick_operand();
        logic [255:0] v;
        v = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(0, 7))
            0: v = '0;
            1: v = '1;
            2: v = v >> (8 * $urandom_range(0, 31));
            3: v = 256'd1 << $urandom_range(0, 255);
            4: v = 256'({$urandom, $urandom});
            default: ;
        endcase
        return v;
    endfunction

    // Offers one word and holds it until accepted; the model learns it at the
    // accepting edge.
    task automatic send_operation(logic [2:0] op, logic [255:0] a, logic [255:0] b,
                                  logic [5:0] nbytes);
        s_valid <= 1'b1;
        s_op <= op;
        {s_a_word3, s_a_word2, s_a_word1, s_a_word0} <= a;
        {s_b_word3, s_b_word2, s_b_word1, s_b_word0} <= b;
        s_shift_bytes <= nbytes;
        do @(posedge aclk); while (!s_ready);
        board.note_operation(op, a, b, nbytes);
    endtask

    task automatic idle_sender(int cycles);
        if (cycles > 0) begin
            s_valid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    // Receiver: a stall pattern with quiet stretches, plus one long hold-off.
    initial begin
        int phase;
        m_ready = 1'b0;
        phase = 0;
        @(posedge aclk iff aresetn);
        forever begin
            @(posedge aclk);
            if (hold_off_now) begin
                m_ready <= 1'b0;
                repeat (1500) @(posedge aclk);
                hold_off_now = 1'b0;
            end
            phase++;
            if ((phase / 200) % 2 == 0) m_ready <= 1'b1;
            else m_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Every accepted result word goes to the scoreboard.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result({m_r_word3, m_r_word2, m_r_word1, m_r_word0},
                               m_a_less, m_a_equal, m_divide_by_zero);
    end

    initial begin
        logic [255:0] all_ones;
        int burst;
        int waited;
        board = new();
        all_ones = '1;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_op = OP_ADD;
        {s_a_word0, s_a_word1, s_a_word2, s_a_word3} = '0;
        {s_b_word0, s_b_word1, s_b_word2, s_b_word3} = '0;
        s_shift_bytes = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: field extremes, each operation and the special cases.
        send_operation(OP_ADD, all_ones, 256'd1, 6'd0);        // carry out dropped
        send_operation(OP_ADD, '0, '0, 6'd63);
        send_operation(OP_SUB, '0, 256'd1, 6'd0);              // borrow out dropped
        send_operation(OP_SUB, all_ones, all_ones, 6'd0);
        send_operation(OP_MUL, all_ones, all_ones, 6'd0);      // product truncated
        send_operation(OP_MUL, 256'd1 << 200, 256'd1 << 100, 6'd0);
        send_operation(OP_DIV, all_ones, '0, 6'd0);            // divide by zero
        send_operation(OP_MOD, all_ones, '0, 6'd0);
        send_operation(OP_DIV, all_ones, 256'd7, 6'd0);
        send_operation(OP_MOD, all_ones, 256'd7, 6'd0);
        send_operation(OP_DIV, 256'd5, all_ones, 6'd0);
        send_operation(OP_MOD, all_ones, all_ones, 6'd0);
        send_operation(OP_SHL, all_ones, '0, 6'd0);
        send_operation(OP_SHL, all_ones, '0, 6'd31);
        send_operation(OP_SHL, all_ones, '0, 6'd32);           // large shift clears
        send_operation(OP_SHR, all_ones, '0, 6'd63);
        send_operation(OP_SHR, all_ones, '0, 6'd9);
        send_operation(OP_CMP, 256'd3, 256'd4, 6'd0);          // compare only
        send_operation(OP_CMP, all_ones, all_ones, 6'd0);
        send_operation(OP_CMP, all_ones, '0, 6'd42);

        // Random part in bursts; the long hold-off starts partway through.
        for (int n = 0; n < 500; ) begin
            burst = $urandom_range(1, 8);
            for (int k = 0; k < burst && n < 500; k++, n++) begin
                if (n == 200) hold_off_now = 1'b1;
                send_operation(3'($urandom_range(0, 7)), pick_operand(),
                               ($urandom_range(0, 3) == 0) ? pick_operand() : pick_operand(),
                               ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                           : 6'($urandom_range(0, 32)));
            end
            idle_sender($urandom_range(0, 300));
        end
        s_valid <= 1'b0;

        waited = 0;
        while (board.pending.size() != 0 && waited < 100000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (600) @(posedge aclk);
        if (board.pending.size() == 0 && board.mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end
endmodule
